// ----- hw/rtl/abfr_pkg.sv -----
package abfr_pkg;

    localparam int ADDR_WIDTH_DEF = 64;
    localparam int DATA_W         = 64;
    localparam int QUEUE_DEPTH    = 2;

    // item kinds
    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_ADD   = 3'd1;
    localparam logic [2:0] KIND_LDST  = 3'd2;
    localparam logic [2:0] KIND_ADRP  = 3'd3;
    localparam logic [2:0] KIND_B     = 3'd4;
    localparam logic [2:0] KIND_BCOND = 3'd5;
    localparam logic [2:0] KIND_BL    = 3'd6;
    localparam logic [2:0] KIND_DATA  = 3'd7;

    // operand modifier combinations (bit0 got, bit1 page, bit2 pageoff)
    localparam logic [2:0] MOD_NONE        = 3'd0;
    localparam logic [2:0] MOD_GOT         = 3'd1;
    localparam logic [2:0] MOD_PAGE        = 3'd2;
    localparam logic [2:0] MOD_GOT_PAGE    = 3'd3;
    localparam logic [2:0] MOD_PAGEOFF     = 3'd4;
    localparam logic [2:0] MOD_GOT_PAGEOFF = 3'd5;

    // relocation types
    localparam logic [2:0] RT_PCREL_HI = 3'd0;
    localparam logic [2:0] RT_PCREL_LO = 3'd1;
    localparam logic [2:0] RT_GOT_HI   = 3'd2;
    localparam logic [2:0] RT_GOT_LO   = 3'd3;
    localparam logic [2:0] RT_CALL     = 3'd4;
    localparam logic [2:0] RT_ABS64    = 3'd5;

    // branch encoding
    localparam logic [31:0] B_WORD_KEEP     = 32'hfc00_0000;
    localparam logic [31:0] BCOND_WORD_KEEP = 32'hff00_001f;
    localparam int          B_RANGE_BIT     = 27;
    localparam int          BCOND_RANGE_BIT = 20;

    typedef struct packed {
        logic                     rvalid;
        logic [2:0]               rtype;
        logic [DATA_W-1:0]        sec_off;
        logic signed [DATA_W-1:0] addend;
        logic                     is_branch;
        logic                     is_b;
        logic [DATA_W-1:0]        target;
        logic [DATA_W-1:0]        addr;
        logic [31:0]              word;
    } entry_t;

endpackage

// ----- hw/rtl/abfr_if.sv -----
interface abfr_item_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic               first_of_section;
    logic [63:0]        item_address;
    logic [31:0]        insn_word;
    logic               operand_ok;
    logic               has_label;
    logic [63:0]        label_address;
    logic [2:0]         modifier;
    logic signed [63:0] expr_offset;

    modport source
    (
        output valid, kind, first_of_section, item_address, insn_word, operand_ok,
               has_label, label_address, modifier, expr_offset,
        input  ready
    );
    modport sink
    (
        input  valid, kind, first_of_section, item_address, insn_word, operand_ok,
               has_label, label_address, modifier, expr_offset,
        output ready
    );
endinterface

interface abfr_result_if;
    logic               valid;
    logic               ready;
    logic               reloc_valid;
    logic [2:0]         reloc_type;
    logic [63:0]        reloc_section_offset;
    logic signed [63:0] reloc_addend;
    logic               patch_valid;
    logic [31:0]        patched_word;
    logic               range_error;

    modport source
    (
        output valid, reloc_valid, reloc_type, reloc_section_offset, reloc_addend,
               patch_valid, patched_word, range_error,
        input  ready
    );
    modport sink
    (
        input  valid, reloc_valid, reloc_type, reloc_section_offset, reloc_addend,
               patch_valid, patched_word, range_error,
        output ready
    );
endinterface

// ----- hw/rtl/abfr_front.sv -----
module abfr_front #(
    parameter int ADDR_WIDTH = abfr_pkg::ADDR_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    abfr_item_if.sink          item_in,
    output logic               push_valid,
    input  logic               push_ready,
    output abfr_pkg::entry_t   push_entry
);

    logic [ADDR_WIDTH-1:0] sec_start_reg;
    logic [ADDR_WIDTH-1:0] sec_start_next;
    logic [ADDR_WIDTH-1:0] addr;
    logic [ADDR_WIDTH-1:0] sec_off;
    logic [ADDR_WIDTH-1:0] label_term;
    logic [ADDR_WIDTH-1:0] target;
    logic                  accept;
    logic                  rvalid;
    logic [2:0]            rtype;
    logic                  is_branch;

    assign item_in.ready = push_ready;
    assign push_valid    = item_in.valid;
    assign accept        = item_in.valid & push_ready;

    assign addr           = item_in.item_address[ADDR_WIDTH-1:0];
    // the first item of a section already sees its own start
    assign sec_start_next = item_in.first_of_section ? addr : sec_start_reg;
    assign sec_off        = addr - sec_start_next;
    assign label_term     = item_in.has_label ? item_in.label_address[ADDR_WIDTH-1:0]
                                              : '0;
    assign target         = item_in.expr_offset[ADDR_WIDTH-1:0] + label_term;

    always_comb
    begin
        rvalid    = 1'b0;
        rtype     = abfr_pkg::RT_PCREL_HI;
        is_branch = 1'b0;
        case (item_in.kind)
            abfr_pkg::KIND_ADD:
            begin
                if (item_in.modifier == abfr_pkg::MOD_PAGEOFF)
                begin
                    rvalid = item_in.has_label;
                    rtype  = abfr_pkg::RT_PCREL_LO;
                end
                else if (item_in.modifier == abfr_pkg::MOD_GOT_PAGEOFF)
                begin
                    rvalid = item_in.has_label;
                    rtype  = abfr_pkg::RT_GOT_LO;
                end
            end
            abfr_pkg::KIND_LDST:
            begin
                if (item_in.modifier == abfr_pkg::MOD_GOT)
                begin
                    rvalid = item_in.has_label;
                    rtype  = abfr_pkg::RT_GOT_HI;
                end
                else if (item_in.modifier == abfr_pkg::MOD_GOT_PAGEOFF)
                begin
                    rvalid = item_in.has_label;
                    rtype  = abfr_pkg::RT_GOT_LO;
                end
            end
            abfr_pkg::KIND_ADRP:
            begin
                if (item_in.modifier == abfr_pkg::MOD_NONE ||
                    item_in.modifier == abfr_pkg::MOD_PAGE)
                begin
                    rvalid = item_in.has_label;
                    rtype  = abfr_pkg::RT_PCREL_HI;
                end
                else if (item_in.modifier == abfr_pkg::MOD_GOT_PAGE)
                begin
                    rvalid = item_in.has_label;
                    rtype  = abfr_pkg::RT_GOT_HI;
                end
            end
            abfr_pkg::KIND_B,
            abfr_pkg::KIND_BCOND:
            begin
                is_branch = 1'b1;
            end
            abfr_pkg::KIND_BL:
            begin
                rvalid = item_in.has_label;
                rtype  = abfr_pkg::RT_CALL;
            end
            abfr_pkg::KIND_DATA:
            begin
                rvalid = item_in.has_label;
                rtype  = abfr_pkg::RT_ABS64;
            end
            default:
            begin
                rvalid    = 1'b0;
                is_branch = 1'b0;
            end
        endcase
    end

    // drop the record and the patch when the operand form is wrong; zero record fields with no record
    always_comb
    begin
        push_entry.rvalid    = rvalid & item_in.operand_ok;
        push_entry.rtype     = push_entry.rvalid ? rtype : abfr_pkg::RT_PCREL_HI;
        push_entry.sec_off   = push_entry.rvalid ? abfr_pkg::DATA_W'(sec_off) : '0;
        push_entry.addend    = push_entry.rvalid ? item_in.expr_offset : '0;
        push_entry.is_branch = is_branch & item_in.operand_ok;
        push_entry.is_b      = (item_in.kind == abfr_pkg::KIND_B);
        push_entry.target    = abfr_pkg::DATA_W'(target);
        push_entry.addr      = abfr_pkg::DATA_W'(addr);
        push_entry.word      = item_in.insn_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_start_reg <= '0;
        end
        else if (accept)
        begin
            sec_start_reg <= sec_start_next;
        end
    end

endmodule

// ----- hw/rtl/abfr_queue.sv -----
module abfr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  abfr_pkg::entry_t   push_entry,
    output logic               pop_valid,
    input  logic               pop_ready,
    output abfr_pkg::entry_t   pop_entry
);

    localparam int PTR_W = (abfr_pkg::QUEUE_DEPTH > 1) ? $clog2(abfr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(abfr_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(abfr_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(abfr_pkg::QUEUE_DEPTH - 1);

    abfr_pkg::entry_t   mem_reg [abfr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hw/rtl/abfr_back.sv -----
module abfr_back #(
    parameter int ADDR_WIDTH = abfr_pkg::ADDR_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  abfr_pkg::entry_t   pop_entry,
    abfr_result_if.source      result_out
);

    logic [ADDR_WIDTH-1:0] off;
    logic                  b_fits;
    logic                  bcond_fits;
    logic                  aligned;
    logic                  in_range;
    logic                  pvalid;
    logic                  rerr;
    logic [31:0]           b_word;
    logic [31:0]           bcond_word;
    logic [31:0]           pword;
    logic                  take;

    logic                  out_valid_reg;
    logic                  reloc_valid_reg;
    logic [2:0]            reloc_type_reg;
    logic [63:0]           sec_off_reg;
    logic signed [63:0]    addend_reg;
    logic                  patch_valid_reg;
    logic [31:0]           word_reg;
    logic                  rerr_reg;

    assign off = pop_entry.target[ADDR_WIDTH-1:0] - pop_entry.addr[ADDR_WIDTH-1:0];

    // signed fit: all bits from the range bit upward equal the sign
    assign b_fits     = (&off[ADDR_WIDTH-1:abfr_pkg::B_RANGE_BIT]) |
                        ~(|off[ADDR_WIDTH-1:abfr_pkg::B_RANGE_BIT]);
    assign bcond_fits = (&off[ADDR_WIDTH-1:abfr_pkg::BCOND_RANGE_BIT]) |
                        ~(|off[ADDR_WIDTH-1:abfr_pkg::BCOND_RANGE_BIT]);
    assign aligned    = (off[1:0] == 2'b00);
    assign in_range   = (pop_entry.is_b ? b_fits : bcond_fits) & aligned;
    assign pvalid     = pop_entry.is_branch & in_range;
    assign rerr       = pop_entry.is_branch & ~in_range;

    assign b_word     = (pop_entry.word & abfr_pkg::B_WORD_KEEP) |
                        {6'b0, off[abfr_pkg::B_RANGE_BIT:2]};
    assign bcond_word = (pop_entry.word & abfr_pkg::BCOND_WORD_KEEP) |
                        {8'b0, off[abfr_pkg::BCOND_RANGE_BIT:0], 3'b0};
    assign pword      = !pvalid          ? pop_entry.word :
                        pop_entry.is_b   ? b_word : bcond_word;

    // advance when the output register is empty or being drained
    assign pop_ready = !out_valid_reg || result_out.ready;
    assign take      = pop_valid & pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop_ready)
        begin
            out_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            reloc_valid_reg <= pop_entry.rvalid;
            reloc_type_reg  <= pop_entry.rtype;
            sec_off_reg     <= pop_entry.sec_off;
            addend_reg      <= pop_entry.addend;
            patch_valid_reg <= pvalid;
            word_reg        <= pword;
            rerr_reg        <= rerr;
        end
    end

    assign result_out.valid                = out_valid_reg;
    assign result_out.reloc_valid          = reloc_valid_reg;
    assign result_out.reloc_type           = reloc_type_reg;
    assign result_out.reloc_section_offset = sec_off_reg;
    assign result_out.reloc_addend         = addend_reg;
    assign result_out.patch_valid          = patch_valid_reg;
    assign result_out.patched_word         = word_reg;
    assign result_out.range_error          = rerr_reg;

endmodule

// ----- hw/rtl/aarch64_branch_fixup_and_reloc_top.sv -----
// An accepted request is written to a queue entry, then registered at the output as its result.
// One request per cycle unless the queue is full; the classify path does the section offset and
// target add, the fixup path does the branch offset subtract, range check and patch.
// A two-entry queue between them and the output register let either side stall alone.
// Reset (rst_n low, async) empties the queue and output register and zeroes section start.
module aarch64_branch_fixup_and_reloc_top #(
    parameter int ADDR_WIDTH = abfr_pkg::ADDR_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    abfr_item_if.sink      item_in,
    abfr_result_if.source  result_out
);

    logic               push_valid;
    logic               push_ready;
    abfr_pkg::entry_t   push_entry;
    logic               pop_valid;
    logic               pop_ready;
    abfr_pkg::entry_t   pop_entry;

    abfr_front #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    abfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    abfr_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .result_out (result_out)
    );

endmodule

// ----- verif/aarch64_branch_fixup_and_reloc_top_tb.sv -----
module aarch64_branch_fixup_and_reloc_top_tb;

    import abfr_pkg::*;

    localparam int RANDOM_ITEMS   = 1275;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_ITEM   = 500;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        logic [2:0]         kind;
        logic               first;
        logic [63:0]        addr;
        logic [31:0]        word;
        logic               opok;
        logic               lab;
        logic [63:0]        laddr;
        logic [2:0]         mod;
        logic signed [63:0] offset;
    } asm_item_t;

    typedef struct {
        logic               rvalid;
        logic [2:0]         rtype;
        logic [63:0]        sec_off;
        logic signed [63:0] addend;
        logic               pvalid;
        logic [31:0]        pword;
        logic               rerr;
    } fixup_t;

    logic clk;
    logic rst_n;

    abfr_item_if   item_bus ();
    abfr_result_if result_bus ();

    aarch64_branch_fixup_and_reloc_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_bus),
        .result_out (result_bus)
    );

    asm_item_t   pending_items[$];
    fixup_t      expected_fixups[$];
    logic [63:0] section_base = '0;

    int items_total     = 0;
    int items_accepted  = 0;
    int results_seen    = 0;
    int mismatch_count  = 0;
    int idle_cycles     = 0;
    bit req_accepted    = 1'b0;
    int send_gap        = 0;
    int recv_stall      = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Both sides run without gaps in every third window of 200 requests.
    function automatic bit calm_phase();
        return ((items_accepted / 200) % 3) == 1;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic fixup_t predict_fixup(asm_item_t it);
        fixup_t             r;
        logic signed [63:0] off;
        logic signed [63:0] lim;
        r = '{default: '0};
        r.pword = it.word;
        if (it.first)
            section_base = it.addr;
        if (it.opok)
        begin
            case (it.kind)
                KIND_ADD:
                    if (it.lab && (it.mod == MOD_PAGEOFF || it.mod == MOD_GOT_PAGEOFF))
                    begin
                        r.rvalid = 1'b1;
                        r.rtype  = (it.mod == MOD_PAGEOFF) ? RT_PCREL_LO : RT_GOT_LO;
                    end
                KIND_LDST:
                    if (it.lab && (it.mod == MOD_GOT || it.mod == MOD_GOT_PAGEOFF))
                    begin
                        r.rvalid = 1'b1;
                        r.rtype  = (it.mod == MOD_GOT) ? RT_GOT_HI : RT_GOT_LO;
                    end
                KIND_ADRP:
                    if (it.lab && (it.mod == MOD_NONE || it.mod == MOD_PAGE
                                   || it.mod == MOD_GOT_PAGE))
                    begin
                        r.rvalid = 1'b1;
                        r.rtype  = (it.mod == MOD_GOT_PAGE) ? RT_GOT_HI : RT_PCREL_HI;
                    end
                KIND_B, KIND_BCOND:
                begin
                    off = it.offset + (it.lab ? it.laddr : 64'd0) - it.addr;
                    lim = (it.kind == KIND_B) ? (64'sd1 <<< B_RANGE_BIT)
                                              : (64'sd1 <<< BCOND_RANGE_BIT);
                    if (off >= lim || off < -lim || off[1:0] != 2'b00)
                        r.rerr = 1'b1;
                    else if (it.kind == KIND_B)
                    begin
                        r.pvalid = 1'b1;
                        r.pword  = (it.word & B_WORD_KEEP) | {6'd0, off[27:2]};
                    end
                    else
                    begin
                        r.pvalid = 1'b1;
                        r.pword  = (it.word & BCOND_WORD_KEEP) | ({11'd0, off[20:0]} << 3);
                    end
                end
                KIND_BL:
                    if (it.lab)
                    begin
                        r.rvalid = 1'b1;
                        r.rtype  = RT_CALL;
                    end
                KIND_DATA:
                    if (it.lab)
                    begin
                        r.rvalid = 1'b1;
                        r.rtype  = RT_ABS64;
                    end
                default:
                    ;
            endcase
        end
        if (r.rvalid)
        begin
            r.sec_off = it.addr - section_base;
            r.addend  = it.offset;
        end
        return r;
    endfunction

    task automatic add_item(input logic [2:0] kind, input logic first, input logic [63:0] addr,
                            input logic [31:0] word, input logic opok, input logic lab,
                            input logic [63:0] laddr, input logic [2:0] mod,
                            input logic [63:0] offset);
        asm_item_t it;
        it.kind   = kind;
        it.first  = first;
        it.addr   = addr;
        it.word   = word;
        it.opok   = opok;
        it.lab    = lab;
        it.laddr  = laddr;
        it.mod    = mod;
        it.offset = offset;
        pending_items.push_back(it);
    endtask

    function automatic asm_item_t random_item();
        asm_item_t          it;
        logic signed [63:0] lim;
        logic signed [63:0] lim_words;
        logic signed [63:0] off;
        it.kind   = 3'($urandom_range(0, 7));
        it.first  = ($urandom_range(0, 19) == 0);
        it.addr   = {$urandom, $urandom};
        it.word   = $urandom;
        it.opok   = ($urandom_range(0, 9) != 0);
        it.lab    = ($urandom_range(0, 4) != 0);
        it.laddr  = {$urandom, $urandom};
        it.mod    = 3'($urandom_range(0, 7));
        it.offset = {$urandom, $urandom};
        // Steer most branches near their reach so the patch path gets exercised.
        if ((it.kind == KIND_B || it.kind == KIND_BCOND) && $urandom_range(0, 9) < 8)
        begin
            lim = (it.kind == KIND_B) ? (64'sd1 <<< B_RANGE_BIT)
                                      : (64'sd1 <<< BCOND_RANGE_BIT);
            if ($urandom_range(0, 9) < 7)
            begin
                lim_words = lim >>> 2;
                off = $signed({32'd0, $urandom_range(0, 32'(2 * lim_words + 3))});
                off = (off - lim_words - 2) <<< 2;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       off = lim - 4;
                    1:       off = lim;
                    2:       off = -lim;
                    default: off = -lim - 4;
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                off = off + $urandom_range(1, 3);
            if (it.lab)
                it.laddr = it.addr + off - it.offset;
            else
                it.offset = it.addr + off;
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got %h expected %h at result %0d", what, got, want,
                 results_seen);
    endtask

    task automatic check_fixup();
        fixup_t want;
        if (expected_fixups.size() == 0)
        begin
            report_mismatch("unexpected result", 64'(result_bus.patched_word), 64'd0);
            return;
        end
        want = expected_fixups.pop_front();
        if (result_bus.reloc_valid !== want.rvalid)
            report_mismatch("reloc_valid", 64'(result_bus.reloc_valid), 64'(want.rvalid));
        if (result_bus.reloc_type !== want.rtype)
            report_mismatch("reloc_type", 64'(result_bus.reloc_type), 64'(want.rtype));
        if (result_bus.reloc_section_offset !== want.sec_off)
            report_mismatch("reloc_section_offset", result_bus.reloc_section_offset,
                            want.sec_off);
        if (result_bus.reloc_addend !== want.addend)
            report_mismatch("reloc_addend", result_bus.reloc_addend, want.addend);
        if (result_bus.patch_valid !== want.pvalid)
            report_mismatch("patch_valid", 64'(result_bus.patch_valid), 64'(want.pvalid));
        if (result_bus.patched_word !== want.pword)
            report_mismatch("patched_word", 64'(result_bus.patched_word), 64'(want.pword));
        if (result_bus.range_error !== want.rerr)
            report_mismatch("range_error", 64'(result_bus.range_error), 64'(want.rerr));
    endtask

    // Sample both handshakes, predict on each accepted request, check each result.
    always @(posedge clk)
    begin
        asm_item_t seen;
        if (rst_n)
        begin
            req_accepted <= item_bus.valid && item_bus.ready;
            if (item_bus.valid && item_bus.ready)
            begin
                seen.kind   = item_bus.kind;
                seen.first  = item_bus.first_of_section;
                seen.addr   = item_bus.item_address;
                seen.word   = item_bus.insn_word;
                seen.opok   = item_bus.operand_ok;
                seen.lab    = item_bus.has_label;
                seen.laddr  = item_bus.label_address;
                seen.mod    = item_bus.modifier;
                seen.offset = item_bus.expr_offset;
                expected_fixups.push_back(predict_fixup(seen));
                items_accepted <= items_accepted + 1;
            end
            if (result_bus.valid && result_bus.ready)
            begin
                check_fixup();
                results_seen <= results_seen + 1;
            end
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Request driver: hold the current request until taken, then idle or advance.
    always @(negedge clk)
    begin
        asm_item_t it;
        if (!rst_n)
            item_bus.valid <= 1'b0;
        else if (!(item_bus.valid && !req_accepted))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_bus.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                item_bus.kind             <= it.kind;
                item_bus.first_of_section <= it.first;
                item_bus.item_address     <= it.addr;
                item_bus.insn_word        <= it.word;
                item_bus.operand_ok       <= it.opok;
                item_bus.has_label        <= it.lab;
                item_bus.label_address    <= it.laddr;
                item_bus.modifier         <= it.mod;
                item_bus.expr_offset      <= it.offset;
                item_bus.valid            <= 1'b1;
                send_gap = calm_phase() ? 0 : pick_gap();
            end
            else
                item_bus.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus one long hold-off that backs up the input.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (!hold_done && items_accepted >= HOLD_AT_ITEM)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                recv_stall = calm_phase() ? 0 : pick_gap();
            end
        end
    end

    initial
    begin
        rst_n                     = 1'b0;
        item_bus.valid            = 1'b0;
        item_bus.kind             = KIND_OTHER;
        item_bus.first_of_section = 1'b0;
        item_bus.item_address     = '0;
        item_bus.insn_word        = '0;
        item_bus.operand_ok       = 1'b0;
        item_bus.has_label        = 1'b0;
        item_bus.label_address    = '0;
        item_bus.modifier         = MOD_NONE;
        item_bus.expr_offset      = '0;
        result_bus.ready          = 1'b0;

        // kind other, record and modifier classes for every relocating kind
        add_item(KIND_OTHER, 1, 64'h1000, 32'hffff_ffff, 1, 1, 64'h5000, MOD_NONE, 64'd8);
        add_item(KIND_ADD, 0, 64'h1004, 32'h9100_0000, 1, 1, 64'h5000, MOD_PAGEOFF,
                 64'h7fff_ffff_ffff_ffff);
        add_item(KIND_ADD, 0, 64'h1008, 32'h9100_0000, 1, 1, 64'h5000, MOD_GOT_PAGEOFF,
                 64'h8000_0000_0000_0000);
        add_item(KIND_ADD, 0, 64'h100c, 32'h9100_0000, 1, 1, 64'h5000, MOD_PAGE, 64'd4);
        add_item(KIND_LDST, 0, 64'h1010, 32'hf940_0000, 1, 1, 64'h5000, MOD_GOT, 64'd0);
        add_item(KIND_LDST, 0, 64'h1014, 32'hf940_0000, 1, 1, 64'h5000, MOD_GOT_PAGEOFF,
                 -64'sd16);
        add_item(KIND_ADRP, 0, 64'h1018, 32'h9000_0000, 1, 1, 64'h5000, MOD_NONE, 64'd1);
        add_item(KIND_ADRP, 0, 64'h101c, 32'h9000_0000, 1, 1, 64'h5000, MOD_PAGE, 64'd2);
        add_item(KIND_ADRP, 0, 64'h1020, 32'h9000_0000, 1, 1, 64'h5000, MOD_GOT_PAGE,
                 64'd3);
        add_item(KIND_ADRP, 0, 64'h1024, 32'h9000_0000, 1, 1, 64'h5000, MOD_PAGEOFF, 64'd3);
        add_item(KIND_BL, 0, 64'h1028, 32'h9400_0000, 1, 1, 64'h5000,
                 MOD_GOT_PAGE | MOD_PAGEOFF, 64'd12);
        add_item(KIND_BL, 0, 64'h102c, 32'h9400_0000, 1, 0, 64'h5000, MOD_NONE, 64'd12);
        add_item(KIND_DATA, 0, 64'h1030, 32'h0, 1, 1, 64'h5000,
                 MOD_GOT_PAGE | MOD_PAGEOFF, 64'd20);
        add_item(KIND_DATA, 0, 64'h1038, 32'h0, 1, 0, 64'h5000, MOD_NONE, 64'd20);
        // operand in the wrong form blocks records and patches alike
        add_item(KIND_ADD, 0, 64'h1040, 32'h9100_0000, 0, 1, 64'h5000, MOD_PAGEOFF, 64'd4);
        add_item(KIND_B, 0, 64'h1044, 32'h1400_0000, 0, 1, 64'h1048, MOD_NONE, 64'd0);
        // branch reach: top of range, one past the top, bottom of range, misaligned
        add_item(KIND_B, 0, 64'h2000, 32'h17ff_ffff, 1, 1, 64'h2000 + (64'd1 << 27) - 4,
                 MOD_NONE, 64'd0);
        add_item(KIND_B, 0, 64'h2000, 32'h1400_0000, 1, 1, 64'h2000 + (64'd1 << 27),
                 MOD_NONE, 64'd0);
        add_item(KIND_B, 0, 64'h2000, 32'h1400_0000, 1, 1, 64'h2000 - (64'd1 << 27),
                 MOD_NONE, 64'd0);
        add_item(KIND_B, 0, 64'h2000, 32'h1400_0000, 1, 1, 64'h2004, MOD_NONE, 64'd2);
        // conditional branches without label: target is the constant alone
        add_item(KIND_BCOND, 0, 64'h3000, 32'h5400_0001, 1, 0, 64'h0, MOD_NONE,
                 64'h3000 + (64'd1 << 20) - 4);
        add_item(KIND_BCOND, 0, 64'h3000, 32'hb400_0003, 1, 0, 64'h0, MOD_NONE,
                 64'h3000 - (64'd1 << 20) - 4);
        add_item(KIND_BCOND, 0, 64'h3000, 32'hffff_ffff, 1, 0, 64'h0, MOD_NONE,
                 64'h3000 - (64'd1 << 20));
        // section start at the top of the address space, then a wrapped offset
        add_item(KIND_DATA, 1, 64'hffff_ffff_ffff_ffff, 32'h0, 1, 1, 64'hffff_ffff_ffff_ffff,
                 MOD_NONE, 64'd0);
        add_item(KIND_DATA, 0, 64'h0, 32'h0, 1, 1, 64'h0, MOD_NONE, 64'd1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_items.push_back(random_item());
        items_total = pending_items.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(negedge clk);
        while (items_accepted < items_total || expected_fixups.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/abfr_pkg.sv
hw/rtl/abfr_if.sv
hw/rtl/abfr_front.sv
hw/rtl/abfr_queue.sv
hw/rtl/abfr_back.sv
hw/rtl/aarch64_branch_fixup_and_reloc_top.sv
verif/aarch64_branch_fixup_and_reloc_top_tb.sv
